### hdl/kla_pkg.sv
// Shared types, widths and codes for the k-th ancestor block.
`timescale 1ns / 1ps
`default_nettype none

package kla_pkg;

    localparam int DEF_NODES  = 1024;
    localparam int DEF_LEVELS = 11;

    localparam int NODE_IN_W  = 10;
    localparam int STEPS_W    = 11;
    localparam int ANC_W      = 10;

    localparam int S_TDATA_W  = 32;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 16;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RB_RD,
        ST_RB_HALF,
        ST_RB_FULL,
        ST_WK_SCAN,
        ST_WK_READ,
        ST_DONE
    } kla_state_t;

    typedef struct packed {
        logic [ANC_W-1:0] ancestor;
        logic             found;
    } kla_res_t;

endpackage

`default_nettype wire

### hdl/kla_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module kla_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### hdl/kla_ctrl.sv
// Sequencer for clearing, table rebuild and ancestor walk over the jump-table RAM.
`timescale 1ns / 1ps
`default_nettype none

module kla_ctrl #(
    parameter int NODES  = kla_pkg::DEF_NODES,
    parameter int LEVELS = kla_pkg::DEF_LEVELS,
    parameter int ADDR_W = 14,
    parameter int ENT_W  = 11
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             in_cmd,
    input  wire logic [kla_pkg::NODE_IN_W-1:0]    in_node,
    input  wire logic [kla_pkg::NODE_IN_W-1:0]    in_par,
    input  wire logic                             in_hasp,
    input  wire logic [kla_pkg::STEPS_W-1:0]      in_steps,
    output logic                                  ram_wr_en,
    output logic      [ADDR_W-1:0]                ram_wr_addr,
    output logic      [ENT_W-1:0]                 ram_wr_data,
    output logic      [ADDR_W-1:0]                ram_rd_addr,
    input  wire logic [ENT_W-1:0]                 ram_rd_data,
    output logic                                  res_valid,
    output kla_pkg::kla_res_t                     res,
    input  wire logic                             res_ready
);

    import kla_pkg::*;

    localparam int NODE_W  = ENT_W - 1;
    localparam int LVL_W   = ADDR_W - NODE_W;
    localparam int LVC_W   = $clog2(LEVELS + 1);
    localparam int DEPTH   = LEVELS * (2 ** NODE_W);
    localparam int WALK_LV = (LEVELS < STEPS_W) ? LEVELS : STEPS_W;

    kla_state_t         state_reg, state_next;
    logic [LVC_W-1:0]   lvl_reg, lvl_next;
    logic [NODE_W-1:0]  vtx_reg, vtx_next;
    logic [ADDR_W-1:0]  clr_reg, clr_next;
    logic [NODE_W-1:0]  node_reg, node_next;
    logic [STEPS_W-1:0] k_reg, k_next;
    logic               ok_reg, ok_next;
    logic               stale_reg, stale_next;

    logic [LVL_W-1:0]   lvl_lo;
    logic [LVL_W-1:0]   lvl_dn;
    logic [NODE_W-1:0]  mid;
    logic               ent_ok;
    logic               adv;
    logic               in_node_ok;
    logic               in_par_ok;

    assign lvl_lo     = lvl_reg[LVL_W-1:0];
    assign lvl_dn     = LVL_W'(lvl_reg - LVC_W'(1));
    assign mid        = ram_rd_data[NODE_W-1:0];
    assign ent_ok     = ram_rd_data[NODE_W] && (32'(mid) < 32'(NODES));
    assign in_node_ok = 32'(in_node) < 32'(NODES);
    assign in_par_ok  = 32'(in_par) < 32'(NODES);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            stale_reg <= 1'b0;
            lvl_reg   <= '0;
            vtx_reg   <= '0;
            ok_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            stale_reg <= stale_next;
            lvl_reg   <= lvl_next;
            vtx_reg   <= vtx_next;
            ok_reg    <= ok_next;
        end
    end

    always_ff @(posedge aclk) begin
        node_reg <= node_next;
        k_reg    <= k_next;
    end

    always_comb begin
        state_next  = state_reg;
        lvl_next    = lvl_reg;
        vtx_next    = vtx_reg;
        clr_next    = clr_reg;
        node_next   = node_reg;
        k_next      = k_reg;
        ok_next     = ok_reg;
        stale_next  = stale_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = '0;
        ram_wr_data = '0;
        ram_rd_addr = '0;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        adv         = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_reg;
                clr_next    = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (in_cmd == CMD_LOAD) begin
                        if (in_node_ok) begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = {LVL_W'(0), NODE_W'(in_node)};
                            ram_wr_data = (in_hasp && in_par_ok) ?
                                          {1'b1, NODE_W'(in_par)} : '0;
                            stale_next  = 1'b1;
                        end
                    end else begin
                        node_next = NODE_W'(in_node);
                        k_next    = in_steps;
                        ok_next   = in_node_ok;
                        vtx_next  = '0;
                        if (stale_reg && (LEVELS > 1)) begin
                            lvl_next   = LVC_W'(1);
                            state_next = ST_RB_RD;
                        end else begin
                            lvl_next   = '0;
                            stale_next = 1'b0;
                            state_next = ST_WK_SCAN;
                        end
                    end
                end
            end
            ST_RB_RD: begin
                ram_rd_addr = {lvl_dn, vtx_reg};
                state_next  = ST_RB_HALF;
            end
            ST_RB_HALF: begin
                if (ent_ok) begin
                    ram_rd_addr = {lvl_dn, mid};
                    state_next  = ST_RB_FULL;
                end else begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = {lvl_lo, vtx_reg};
                    adv         = 1'b1;
                end
            end
            ST_RB_FULL: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = {lvl_lo, vtx_reg};
                ram_wr_data = ram_rd_data;
                adv         = 1'b1;
            end
            ST_WK_SCAN: begin
                if (!ok_reg || (lvl_reg == LVC_W'(WALK_LV))) begin
                    state_next = ST_DONE;
                end else if (k_reg[0]) begin
                    ram_rd_addr = {lvl_lo, node_reg};
                    state_next  = ST_WK_READ;
                end else begin
                    k_next   = k_reg >> 1;
                    lvl_next = lvl_reg + LVC_W'(1);
                end
            end
            ST_WK_READ: begin
                if (ent_ok) begin
                    node_next = mid;
                end else begin
                    ok_next = 1'b0;
                end
                k_next     = k_reg >> 1;
                lvl_next   = lvl_reg + LVC_W'(1);
                state_next = ST_WK_SCAN;
            end
            ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // advance to the next node, then the next level, then start the walk
        if (adv) begin
            vtx_next   = vtx_reg + NODE_W'(1);
            state_next = ST_RB_RD;
            if (vtx_reg == NODE_W'(NODES - 1)) begin
                vtx_next = '0;
                lvl_next = lvl_reg + LVC_W'(1);
                if (lvl_reg == LVC_W'(LEVELS - 1)) begin
                    stale_next = 1'b0;
                    lvl_next   = '0;
                    state_next = ST_WK_SCAN;
                end
            end
        end
    end

    assign res.ancestor = ok_reg ? ANC_W'(node_reg) : '0;
    assign res.found    = ok_reg;

endmodule

`default_nettype wire

### hdl/kth_ancestor_binary_lifting.sv
// Top level of the binary-lifting k-th ancestor block with its output register.
`timescale 1ns / 1ps
`default_nettype none

// Holds a forest of NODES nodes as a jump table in one RAM of
// LEVELS x 2^ceil(log2(NODES)) entries; entry (level, node) is the
// 2^level-th ancestor. A load item (tuser command = 0) writes a node's parent
// and gives no result. A query item (command = 1) climbs by the set bits of
// steps and returns one result: ancestor in tdata, found in tuser. The walk
// covers levels 0 to WALK-1, where WALK is min(LEVELS, 11), and every jump is
// one read of the single RAM read port. The first query after any load first
// rebuilds levels 1 to LEVELS-1, each entry from one or two reads of the level
// below. After reset the block clears all LEVELS x 2^ceil(log2(NODES)) RAM
// entries with s_tready low. The next item is taken while a result still waits
// on the output.
module kth_ancestor_binary_lifting #(
    parameter int NODES  = kla_pkg::DEF_NODES,
    parameter int LEVELS = kla_pkg::DEF_LEVELS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // node_id[9:0], parent_id[19:10], steps[30:20], zero[31]
    input  wire logic [kla_pkg::S_TDATA_W-1:0] s_tdata,
    // command[0], has_parent[1]
    input  wire logic [kla_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // ancestor[9:0], zero[15:10]
    output logic      [kla_pkg::M_TDATA_W-1:0] m_tdata,
    // found
    output logic                               m_tuser
);

    import kla_pkg::*;

    localparam int NODE_W = $clog2(NODES);
    localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int ADDR_W = LVL_W + NODE_W;
    localparam int ENT_W  = NODE_W + 1;
    localparam int DEPTH  = LEVELS * (2 ** NODE_W);

    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [ENT_W-1:0]  ram_wr_data;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [ENT_W-1:0]  ram_rd_data;

    logic              res_valid;
    logic              res_ready;
    kla_res_t          res;

    logic              m_valid_reg;
    logic [ANC_W-1:0]  m_anc_reg;
    logic              m_found_reg;

    kla_ctrl #(
        .NODES  (NODES),
        .LEVELS (LEVELS),
        .ADDR_W (ADDR_W),
        .ENT_W  (ENT_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_cmd      (s_tuser[0]),
        .in_node     (s_tdata[9:0]),
        .in_par      (s_tdata[19:10]),
        .in_hasp     (s_tuser[1]),
        .in_steps    (s_tdata[30:20]),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .res_valid   (res_valid),
        .res         (res),
        .res_ready   (res_ready)
    );

    kla_ram #(
        .WIDTH  (ENT_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_anc_reg   <= res.ancestor;
            m_found_reg <= res.found;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_anc_reg);
    assign m_tuser  = m_found_reg;

endmodule

`default_nettype wire

### hdl/kla_chk.sv
// Port-level checks for the k-th ancestor block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module kla_chk (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [kla_pkg::S_TUSER_W-1:0] s_tuser,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [kla_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                          m_tuser
);

    import kla_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_not_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("ancestor not zero on a miss");

    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == CMD_QUERY) |=> !s_tready)
        else $error("query accepted without going busy");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("result or ready shown right after reset");

endmodule

bind kth_ancestor_binary_lifting kla_chk u_kla_chk (.*);

`default_nettype wire

### tb/kth_ancestor_binary_lifting_test.sv
// Testbench for the k-th ancestor block: stream driver, result monitor and jump-table predictor.
`timescale 1ns / 1ps

module kth_ancestor_binary_lifting_test;

    import kla_pkg::*;

    localparam int NODES       = DEF_NODES;
    localparam int LEVELS      = DEF_LEVELS;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int MAX_REPORTS = 10;
    localparam int SEND_IDLE [4] = '{0, 74, 0, 6};
    localparam int RECV_IDLE [4] = '{0, 0, 74, 6};

    typedef struct {
        logic                 cmd;
        logic [NODE_IN_W-1:0] node;
        logic [NODE_IN_W-1:0] parent;
        logic                 has_parent;
        logic [STEPS_W-1:0]   steps;
    } tree_op_t;

    typedef struct packed {
        logic                 valid;
        logic [NODE_IN_W-1:0] id;
    } jump_entry_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    tree_op_t             pending_ops [$];
    tree_op_t             driven_op;
    kla_res_t             expected_answers [$];
    jump_entry_t          jump_tbl [LEVELS][NODES];
    logic                 jumps_stale = 1'b0;
    logic                 in_fire = 1'b0;
    logic [NODE_IN_W-1:0] loaded_nodes [$];
    logic [NODE_IN_W-1:0] chain_tip = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int ops_pushed = 0;
    int ops_accepted = 0;
    int loads_sent = 0;
    int queries_sent = 0;
    int answers_found = 0;
    int answers_missing = 0;
    int mismatches = 0;
    int cycle_count = 0;

    kth_ancestor_binary_lifting dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic kla_res_t predict_ancestor(tree_op_t op);
        jump_entry_t          half;
        logic [NODE_IN_W-1:0] at;
        logic                 ok;
        kla_res_t             res;
        if (jumps_stale) begin
            for (int lv = 1; lv < LEVELS; lv++) begin
                for (int v = 0; v < NODES; v++) begin
                    half = jump_tbl[lv-1][v];
                    jump_tbl[lv][v] = half.valid ? jump_tbl[lv-1][half.id] : '0;
                end
            end
            jumps_stale = 1'b0;
        end
        at = op.node;
        ok = 1'b1;
        for (int lv = 0; lv < LEVELS && lv < STEPS_W; lv++) begin
            if (ok && op.steps[lv]) begin
                if (!jump_tbl[lv][at].valid) begin
                    ok = 1'b0;
                end else begin
                    at = jump_tbl[lv][at].id;
                end
            end
        end
        res.ancestor = ok ? at : '0;
        res.found    = ok;
        return res;
    endfunction

    task automatic push_load(input logic [NODE_IN_W-1:0] node,
                             input logic [NODE_IN_W-1:0] parent, input logic has_parent);
        tree_op_t op;
        op.cmd        = CMD_LOAD;
        op.node       = node;
        op.parent     = parent;
        op.has_parent = has_parent;
        op.steps      = STEPS_W'($urandom_range(0, 2047));
        pending_ops.push_back(op);
        ops_pushed++;
        loads_sent++;
        loaded_nodes.push_back(node);
    endtask

    task automatic push_query(input logic [NODE_IN_W-1:0] node, input logic [STEPS_W-1:0] steps);
        tree_op_t op;
        op.cmd        = CMD_QUERY;
        op.node       = node;
        op.parent     = NODE_IN_W'($urandom_range(0, 1023));
        op.has_parent = 1'($urandom_range(0, 1));
        op.steps      = steps;
        pending_ops.push_back(op);
        ops_pushed++;
        queries_sent++;
    endtask

    task automatic random_load();
        int                   pick;
        logic [NODE_IN_W-1:0] node;
        pick = $urandom_range(0, 99);
        node = NODE_IN_W'($urandom_range(0, 1023));
        if (pick < 60) begin
            push_load(node, chain_tip, 1'b1);
            chain_tip = node;
        end else if (pick < 85) begin
            push_load(node, NODE_IN_W'($urandom_range(0, 1023)), 1'b1);
        end else if (pick < 95) begin
            push_load(node, NODE_IN_W'($urandom_range(0, 1023)), 1'b0);
        end else begin
            push_load(node, node, 1'b1);
        end
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (ops_accepted != ops_pushed || expected_answers.size() != 0);
    endtask

    // Item driver: hold the item until taken, then advance or idle.
    always @(negedge aclk) begin
        tree_op_t op;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fire) begin
            if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                op = pending_ops.pop_front();
                driven_op = op;
                s_tdata  <= {1'b0, op.steps, op.parent, op.node};
                s_tuser  <= {op.has_parent, op.cmd};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        in_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            ops_accepted++;
            if (driven_op.cmd == CMD_LOAD) begin
                jump_tbl[0][driven_op.node] = driven_op.has_parent ?
                    jump_entry_t'{1'b1, driven_op.parent} : '0;
                jumps_stale = 1'b1;
            end else begin
                expected_answers.push_back(predict_ancestor(driven_op));
            end
        end
    end

    // Result monitor: compare each answer with the oldest prediction.
    always @(posedge aclk) begin
        kla_res_t got;
        kla_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.ancestor = m_tdata[ANC_W-1:0];
            got.found    = m_tuser;
            if (got.found) begin
                answers_found++;
            end else begin
                answers_missing++;
            end
            if (expected_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected answer: ancestor %0d found %0d",
                             got.ancestor, got.found);
                end
            end else begin
                want = expected_answers.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("answer mismatch: expected ancestor %0d found %0d, got %0d found %0d",
                                 want.ancestor, want.found, got.ancestor, got.found);
                    end
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[kth_ancestor_binary_lifting] ERROR");
        $finish;
    end

    initial begin
        int                   n_loads;
        int                   n_queries;
        int                   pick;
        logic [NODE_IN_W-1:0] qnode;
        logic [STEPS_W-1:0]   qsteps;
        for (int lv = 0; lv < LEVELS; lv++) begin
            for (int v = 0; v < NODES; v++) begin
                jump_tbl[lv][v] = '0;
            end
        end
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty forest: every node is a root
        push_query(10'd0, 11'd0);
        push_query(10'd1023, 11'd1);
        push_query(10'd5, 11'd2047);
        // chain 4 -> 1023 -> 3 -> 2 -> 1 -> 0, with 0 a root
        push_load(10'd1, 10'd0, 1'b1);
        push_load(10'd2, 10'd1, 1'b1);
        push_load(10'd3, 10'd2, 1'b1);
        push_load(10'd1023, 10'd3, 1'b1);
        push_load(10'd0, 10'd1023, 1'b0);
        push_load(10'd4, 10'd1023, 1'b1);
        push_query(10'd1023, 11'd4);
        push_query(10'd1023, 11'd5);
        push_query(10'd4, 11'd3);
        push_query(10'd4, 11'd1024);
        push_query(10'd3, 11'd0);
        // two-node cycle and a self loop
        push_load(10'd10, 10'd11, 1'b1);
        push_load(10'd11, 10'd10, 1'b1);
        push_load(10'd12, 10'd12, 1'b1);
        push_query(10'd10, 11'd2047);
        push_query(10'd11, 11'd1024);
        push_query(10'd12, 11'd1536);
        push_query(10'd999, 11'd7);
        chain_tip = 10'd4;
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = SEND_IDLE[ph];
            recv_idle_pct = RECV_IDLE[ph];
            for (int b = 0; b < 2; b++) begin
                n_loads = $urandom_range(80, 110);
                repeat (n_loads) random_load();
                n_queries = $urandom_range(90, 110);
                for (int q = 0; q < n_queries; q++) begin
                    // drop a stray load into the query stream once per phase
                    if (b == 1 && q == n_queries / 2) begin
                        random_load();
                    end
                    pick = $urandom_range(0, 99);
                    if (pick < 40) begin
                        qnode = chain_tip;
                    end else if (pick < 70) begin
                        qnode = loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
                    end else begin
                        qnode = NODE_IN_W'($urandom_range(0, 1023));
                    end
                    pick = $urandom_range(0, 99);
                    if (pick < 40) begin
                        qsteps = STEPS_W'($urandom_range(0, 15));
                    end else if (pick < 70) begin
                        qsteps = STEPS_W'($urandom_range(0, 700));
                    end else begin
                        qsteps = STEPS_W'($urandom_range(0, 2047));
                    end
                    push_query(qnode, qsteps);
                end
            end
            wait_drained();
        end

        repeat (64) @(posedge aclk);
        $display("covered %0d loads and %0d queries over four idling phases",
                 loads_sent, queries_sent);
        $display("answers with an ancestor: %0d, walks past a root: %0d, mismatches: %0d",
                 answers_found, answers_missing, mismatches);
        if (mismatches == 0 && expected_answers.size() == 0) begin
            $display("[kth_ancestor_binary_lifting] OK");
        end else begin
            $display("[kth_ancestor_binary_lifting] ERROR");
        end
        $finish;
    end

endmodule

### files.f
hdl/kla_pkg.sv
hdl/kla_ram.sv
hdl/kla_ctrl.sv
hdl/kth_ancestor_binary_lifting.sv
hdl/kla_chk.sv
tb/kth_ancestor_binary_lifting_test.sv
